@@ src/wmc_pkg.sv @@
package wmc_pkg;

  // Controller states; those that report a status follow the order of the status codes
  typedef enum logic [3:0] {
    ST_UNKNOWN         = 4'd0,
    ST_UNKNOWN_WAIT    = 4'd1,
    ST_CLOSED          = 4'd2,
    ST_OPEN            = 4'd3,
    ST_WAIT_ENABLE     = 4'd4,
    ST_WAIT_DIS_OPEN   = 4'd5,
    ST_WAIT_DIS_CLOSED = 4'd6,
    ST_WAIT_DIS_ERROR  = 4'd7,
    ST_CLOSING         = 4'd8,
    ST_OPENING         = 4'd9,
    ST_ERROR           = 4'd10
  } state_e;

  typedef enum logic [1:0] {
    TG_UNKNOWN = 2'd0,
    TG_CLOSED  = 2'd1,
    TG_OPEN    = 2'd2
  } target_e;

  typedef enum logic [1:0] {
    POS_OFF    = 2'd0,
    POS_CLOSED = 2'd1,
    POS_OPEN   = 2'd2,
    POS_AUTO   = 2'd3
  } position_e;

  typedef enum logic [2:0] {
    STAT_UNKNOWN = 3'd0,
    STAT_CLOSED  = 3'd1,
    STAT_OPEN    = 3'd2,
    STAT_CLOSING = 3'd3,
    STAT_OPENING = 3'd4,
    STAT_ERROR   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    CFG_SENSOR_PRESENT      = 3'd0,
    CFG_SENSOR_CLOSED_LEVEL = 3'd1,
    CFG_LINE_POLARITY       = 3'd2,
    CFG_ENABLE_PRESENT      = 3'd3,
    CFG_ENABLE_DELAY_MS     = 3'd4,
    CFG_MOTOR_DELAY_MS      = 3'd5,
    CFG_OPENING_TIME_MS     = 3'd6,
    CFG_CLOSING_TIME_MS     = 3'd7
  } cfg_idx_e;

  localparam int unsigned CfgWidth = 24;

  localparam logic            CMD_TICK  = 1'b0;
  localparam logic            CMD_WRITE = 1'b1;

  typedef struct packed {
    logic       command;
    logic [1:0] new_position;
    logic       sensor_line;
    logic       force_close_any;
    logic       reset_any;
    logic       auto_close_any;
    logic       auto_open_any;
  } in_item_t;

  typedef struct packed {
    logic       motor_a_line;
    logic       motor_b_line;
    logic       enable_line;
    logic       error_line;
    logic [3:0] window_state;
    logic [1:0] target_code;
    logic       status_valid;
    logic [2:0] status_code;
    logic       refresh_pulse;
    logic       position_fault;
    logic [1:0] position_now;
  } out_item_t;

endpackage

@@ src/wmc_chan.sv @@
interface wmc_chan #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/window_motor_controller.sv @@
// Motorized window controller.
// in_i carries items: a one-millisecond tick (with the sampled sensor line and
// the ORed force-close, error-reset, auto-close and auto-open lines) or a
// position write. Every accepted item yields exactly one result item on out_o
// holding the motor, enable and error drive levels, the state and target
// codes, the status report and refresh pulse of this step, the position fault and the selected position.
// cfg_we_i/cfg_idx_i/cfg_wdata_i write the configuration registers; write
// only while no result is pending.
// The result is valid the cycle after the item is accepted.
// Throughput: one item per cycle while the receiver takes each result. The
// whole state update is a single pass of compare and select logic between
// the controller registers and the output register.
// When the receiver stalls, the output register holds its item and in_i.ready
// drops until it is taken; a new item is accepted in the same cycle the held
// one leaves.
// Reset puts the controller in the unknown state, target unknown, position off,
// timers at zero, all drive lines low and the registers at their defaults.
module window_motor_controller
  import wmc_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i,
  wmc_chan.sink               in_i,
  wmc_chan.source             out_o
);

  localparam int unsigned CmpW = (TIMER_BITS > CfgWidth) ? TIMER_BITS : CfgWidth;

  typedef logic [TIMER_BITS-1:0] cnt_t;

  // Working copy of the controller during one step
  typedef struct packed {
    state_e     st;
    target_e    tg;
    cnt_t       dc;
    cnt_t       rc;
    logic       run;
    logic [2:0] drv;   // bit0 A, bit1 B, bit2 enable
    logic       sv;
    status_e    code;
    logic       rf;
  } work_t;

  function automatic work_t set_state(work_t w, state_e s);
    work_t r;
    r = w;
    if (w.st != s) begin
      r.st = s;
      if (s == ST_UNKNOWN || s == ST_ERROR) r.tg = TG_UNKNOWN;
      if (s == ST_UNKNOWN || s == ST_CLOSED || s == ST_OPEN || s == ST_ERROR) r.rf = 1'b1;
      case (s)
        ST_UNKNOWN: begin r.sv = 1'b1; r.code = STAT_UNKNOWN; end
        ST_CLOSED:  begin r.sv = 1'b1; r.code = STAT_CLOSED;  end
        ST_OPEN:    begin r.sv = 1'b1; r.code = STAT_OPEN;    end
        ST_CLOSING: begin r.sv = 1'b1; r.code = STAT_CLOSING; end
        ST_OPENING: begin r.sv = 1'b1; r.code = STAT_OPENING; end
        ST_ERROR:   begin r.sv = 1'b1; r.code = STAT_ERROR;   end
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic work_t set_motor(work_t w, logic a, logic b, logic run);
    work_t r;
    r = w;
    r.drv[0] = a;
    r.drv[1] = b;
    r.run = run;
    return r;
  endfunction

  function automatic work_t set_enable(work_t w, logic present, logic lvl, logic on);
    work_t r;
    r = w;
    if (present) r.drv[2] = on ? lvl : ~lvl;
    return r;
  endfunction

  function automatic logic expired(cnt_t cnt, logic [CfgWidth-1:0] lim);
    return CmpW'(cnt) > CmpW'(lim);
  endfunction

  function automatic cnt_t bump(cnt_t c);
    return (c == '1) ? c : c + cnt_t'(1);
  endfunction

  // Configuration registers
  logic                sensor_present_q, sensor_closed_level_q, enable_present_q;
  logic [1:0]          line_polarity_q;
  logic [CfgWidth-1:0] enable_delay_q, motor_delay_q, opening_time_q, closing_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_present_q      <= 1'b0;
      sensor_closed_level_q <= 1'b1;
      line_polarity_q       <= 2'd3;
      enable_present_q      <= 1'b0;
      enable_delay_q        <= '0;
      motor_delay_q         <= '0;
      opening_time_q        <= CfgWidth'(1000);
      closing_time_q        <= CfgWidth'(1000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SENSOR_PRESENT:      sensor_present_q      <= cfg_wdata_i[0];
        CFG_SENSOR_CLOSED_LEVEL: sensor_closed_level_q <= cfg_wdata_i[0];
        CFG_LINE_POLARITY:       line_polarity_q       <= cfg_wdata_i[1:0];
        CFG_ENABLE_PRESENT:      enable_present_q      <= cfg_wdata_i[0];
        CFG_ENABLE_DELAY_MS:     enable_delay_q        <= cfg_wdata_i;
        CFG_MOTOR_DELAY_MS:      motor_delay_q         <= cfg_wdata_i;
        CFG_OPENING_TIME_MS:     opening_time_q        <= cfg_wdata_i;
        CFG_CLOSING_TIME_MS:     closing_time_q        <= cfg_wdata_i;
      endcase
    end
  end

  // Controller state
  state_e     state_q;
  target_e    target_q;
  cnt_t       delay_cnt_q, run_cnt_q;
  position_e  pos_q, pos_d;
  logic       fresh_q, fresh_d;
  logic       run_q;
  logic [2:0] drv_q;
  work_t      w;

  // Output register
  logic       out_valid_q;
  out_item_t  out_q, out_d;
  logic       accept;

  assign in_i.ready  = ~out_valid_q | out_o.ready;
  assign accept      = in_i.valid & in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // One step of the controller
  always_comb begin
    logic      sc, force_cl, pol_m, pol_e, edly;
    target_e   t;
    in_item_t  it;
    it    = in_i.data;
    pol_m = line_polarity_q[0];
    pol_e = line_polarity_q[1];
    edly  = (enable_delay_q != '0);
    sc    = sensor_present_q & (it.sensor_line == sensor_closed_level_q);
    force_cl = 1'b0;
    t     = TG_UNKNOWN;

    w.st   = state_q;
    w.tg   = target_q;
    w.dc   = delay_cnt_q;
    w.rc   = run_cnt_q;
    w.run  = run_q;
    w.drv  = drv_q;
    w.sv   = 1'b0;
    w.code = STAT_UNKNOWN;
    w.rf   = 1'b0;
    pos_d   = pos_q;
    fresh_d = fresh_q;

    if (it.command == CMD_WRITE) begin
      // position write
      if (state_q == ST_ERROR || pos_q != position_e'(it.new_position)) begin
        pos_d   = position_e'(it.new_position);
        fresh_d = 1'b1;
      end
    end else begin
      w.dc = bump(w.dc);
      w.rc = bump(w.rc);

      unique case (w.st)
        ST_UNKNOWN: begin
          w = set_motor(w, ~pol_m, ~pol_m, 1'b0);
          w = set_enable(w, enable_present_q, pol_e, 1'b0);
          w = set_state(w, sc ? ST_CLOSED : ST_UNKNOWN_WAIT);
          if (pos_q == POS_OPEN) w.tg = TG_OPEN;
          else if (pos_q == POS_CLOSED) w.tg = TG_CLOSED;
        end
        ST_UNKNOWN_WAIT, ST_OPEN, ST_CLOSED: begin
          if (w.st == ST_UNKNOWN_WAIT && sc) begin
            w = set_state(w, ST_CLOSED);
          end else if ((w.st == ST_UNKNOWN_WAIT && w.tg != TG_UNKNOWN) ||
                       (w.st == ST_OPEN && w.tg == TG_CLOSED) ||
                       (w.st == ST_CLOSED && w.tg == TG_OPEN)) begin
            // start a move toward the target
            if (edly) begin
              w.dc = '0;
              w = set_enable(w, enable_present_q, pol_e, 1'b1);
              w = set_state(w, ST_WAIT_ENABLE);
            end else begin
              w.rc = '0;
              if (w.tg == TG_OPEN) begin
                w = set_motor(w, pol_m, ~pol_m, 1'b1);
                w = set_state(w, ST_OPENING);
              end else begin
                w = set_motor(w, ~pol_m, pol_m, 1'b1);
                w = set_state(w, ST_CLOSING);
              end
            end
          end
        end
        ST_WAIT_ENABLE: begin
          if (expired(w.dc, enable_delay_q)) begin
            if (w.tg == TG_OPEN) begin
              w.rc = '0;
              w = set_motor(w, pol_m, ~pol_m, 1'b1);
              w = set_state(w, ST_OPENING);
            end else if (w.tg == TG_CLOSED) begin
              w.rc = '0;
              w = set_motor(w, ~pol_m, pol_m, 1'b1);
              w = set_state(w, ST_CLOSING);
            end else begin
              w = set_state(w, ST_UNKNOWN_WAIT);
            end
          end
        end
        ST_WAIT_DIS_OPEN: begin
          if (w.tg == TG_CLOSED) begin
            w.rc = '0;
            w = set_motor(w, ~pol_m, pol_m, 1'b1);
            w = set_state(w, ST_CLOSING);
          end else if (expired(w.dc, enable_delay_q)) begin
            w = set_enable(w, enable_present_q, pol_e, 1'b0);
            w = set_state(w, ST_OPEN);
          end
        end
        ST_WAIT_DIS_CLOSED: begin
          if (w.tg == TG_OPEN) begin
            w.rc = '0;
            w = set_motor(w, pol_m, ~pol_m, 1'b1);
            w = set_state(w, ST_OPENING);
          end else begin
            // motor run-on after the sensor reported closed
            if (w.run && expired(w.dc, motor_delay_q))
              w = set_motor(w, ~pol_m, ~pol_m, 1'b0);
            if (expired(w.dc, enable_delay_q)) begin
              w = set_enable(w, enable_present_q, pol_e, 1'b0);
              w = set_state(w, ST_CLOSED);
            end
          end
        end
        ST_WAIT_DIS_ERROR: begin
          if (expired(w.dc, enable_delay_q)) begin
            w = set_enable(w, enable_present_q, pol_e, 1'b0);
            w = set_state(w, ST_ERROR);
          end
        end
        ST_OPENING: begin
          if (w.tg == TG_CLOSED) begin
            w.rc = '0;
            w = set_motor(w, ~pol_m, pol_m, 1'b1);
            w = set_state(w, ST_CLOSING);
          end else if (expired(w.rc, opening_time_q)) begin
            w = set_motor(w, ~pol_m, ~pol_m, 1'b0);
            if (edly) begin
              w.dc = '0;
              w = set_state(w, sc ? ST_WAIT_DIS_ERROR : ST_WAIT_DIS_OPEN);
            end else begin
              w = set_state(w, sc ? ST_ERROR : ST_OPEN);
            end
          end
        end
        ST_CLOSING: begin
          if (w.tg == TG_OPEN) begin
            w.rc = '0;
            w = set_motor(w, pol_m, ~pol_m, 1'b1);
            w = set_state(w, ST_OPENING);
          end else if (sc) begin
            if (edly) begin
              w.dc = '0;
              w = set_state(w, ST_WAIT_DIS_CLOSED);
            end else begin
              w = set_state(w, ST_CLOSED);
            end
          end else if (expired(w.rc, closing_time_q)) begin
            w = set_motor(w, ~pol_m, ~pol_m, 1'b0);
            if (edly) begin
              w.dc = '0;
              w = set_state(w, sensor_present_q ? ST_WAIT_DIS_ERROR : ST_WAIT_DIS_CLOSED);
            end else begin
              w = set_state(w, sensor_present_q ? ST_ERROR : ST_CLOSED);
            end
          end
        end
        default: ;
      endcase

      // force-close and error reset
      if (w.st != ST_ERROR) begin
        force_cl = it.force_close_any;
      end else if (it.reset_any) begin
        w = set_state(w, ST_UNKNOWN);
        force_cl = 1'b1;
      end

      if (force_cl) begin
        w.tg = TG_CLOSED;
      end else begin
        // automatic lines or a fresh position select the target; a fresh off position resets the state to unknown
        if (w.st != ST_ERROR && pos_q == POS_AUTO) begin
          if (it.auto_close_any) t = TG_CLOSED;
          else if (it.auto_open_any) t = TG_OPEN;
        end else if (fresh_q && pos_q == POS_OFF) begin
          w = set_state(w, ST_UNKNOWN);
        end else if (fresh_q && pos_q == POS_OPEN) begin
          t = TG_OPEN;
        end else if (fresh_q && pos_q == POS_CLOSED) begin
          t = TG_CLOSED;
        end
        fresh_d = 1'b0;
        if (t != TG_UNKNOWN) begin
          w.tg = t;
          if (w.st == ST_ERROR) w = set_state(w, ST_UNKNOWN_WAIT);
        end
      end
    end
  end

  // result item
  always_comb begin
    out_d.motor_a_line   = w.drv[0];
    out_d.motor_b_line   = w.drv[1];
    out_d.enable_line    = enable_present_q & w.drv[2];
    out_d.error_line     = (w.st == ST_ERROR);
    out_d.window_state   = w.st;
    out_d.target_code    = w.tg;
    out_d.status_valid   = w.sv;
    out_d.status_code    = w.sv ? w.code : STAT_UNKNOWN;
    out_d.refresh_pulse  = w.rf;
    out_d.position_fault = (w.st == ST_ERROR);
    out_d.position_now   = pos_d;
  end

  // State update on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_UNKNOWN;
      target_q    <= TG_UNKNOWN;
      delay_cnt_q <= '0;
      run_cnt_q   <= '0;
      pos_q       <= POS_OFF;
      fresh_q     <= 1'b0;
      run_q       <= 1'b0;
      drv_q       <= '0;
    end else if (accept) begin
      state_q     <= w.st;
      target_q    <= w.tg;
      delay_cnt_q <= w.dc;
      run_cnt_q   <= w.rc;
      pos_q       <= pos_d;
      fresh_q     <= fresh_d;
      run_q       <= w.run;
      drv_q       <= w.drv;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) out_q <= out_d;
  end

endmodule
